// File: rtl/dds_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 64 KiB descriptor splitter.
// Used by the front classifier, the command queue and the descriptor back end.
package dds_pkg;

  localparam int unsigned AddrInW  = 40;
  localparam int unsigned LenW     = 26;
  localparam int unsigned EntAddrW = 32;
  localparam int unsigned EntLenW  = 16;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CountW   = 7;
  // Span between a start offset and the next 64 KiB boundary, up to 65536.
  localparam int unsigned SegW     = 17;
  // Descriptors per chunk, up to 1025.
  localparam int unsigned NumW     = 11;

  localparam logic [SegW-1:0] Boundary = 17'h10000;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_ADDR = 2'd1,
    ERR_FULL = 2'd2
  } err_e;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_e;

  // One classified chunk as it travels from the front to the back end.
  typedef struct packed {
    logic [EntAddrW-1:0] addr;
    logic [LenW-1:0]     len;
    logic [IdxW-1:0]     idx;
    logic                last;
    err_e                err;
  } chunk_cmd_t;

endpackage

// File: rtl/dds_core_top.sv
`timescale 1ns / 1ps
// Top level of the 64 KiB descriptor splitter: front classifier, command
// queue and descriptor back end. Depends on dds_pkg and the dds_* modules.
//
// Usage: chunks enter on the input channel (in_valid_i / in_stall_o), each an
// address, a length and first/last flags. Descriptors leave on the output
// channel (out_valid_o / out_stall_i), one per cycle within a chunk while the
// receiver does not stall; none crosses a 64 KiB boundary and a length of 0
// means 65536. The front classifies a chunk in the cycle it is accepted, so
// the table count, the failure flag and the error decision are settled at
// acceptance. A four-entry queue holds classified chunks; the input stalls
// only when it is full. The back end loads a chunk from the queue in its
// idle state and then emits its descriptors; the first descriptor of a chunk
// passes through the queue, the load and the output register. Chunks that
// yield nothing (zero length, or a failed table) stop at the front and never
// enter the queue.
// A stalled result holds in the output register while the back end waits.
// Reset clears the table count, the failure flag, the queue and the output.
module dma_descriptor_splitter_64k_core import dds_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [AddrInW-1:0]  chunk_address_i,
  input  logic [LenW-1:0]     chunk_length_i,
  input  logic                first_chunk_i,
  input  logic                last_chunk_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [EntAddrW-1:0] entry_address_o,
  output logic [EntLenW-1:0]  entry_length_o,
  output logic                end_of_table_o,
  output logic [IdxW-1:0]     entry_index_o,
  output logic [1:0]          error_code_o,
  output logic                run_last_o
);

  logic       push, pop, full, empty;
  chunk_cmd_t cmd_in, cmd_out;

  dds_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .chunk_address_i (chunk_address_i),
    .chunk_length_i  (chunk_length_i),
    .first_chunk_i   (first_chunk_i),
    .last_chunk_i    (last_chunk_i),
    .full_i          (full),
    .push_o          (push),
    .cmd_o           (cmd_in)
  );

  dds_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (cmd_out),
    .empty_o (empty)
  );

  dds_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .cmd_i           (cmd_out),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .entry_address_o (entry_address_o),
    .entry_length_o  (entry_length_o),
    .end_of_table_o  (end_of_table_o),
    .entry_index_o   (entry_index_o),
    .error_code_o    (error_code_o),
    .run_last_o      (run_last_o)
  );

endmodule

// File: rtl/dds_front.sv
`timescale 1ns / 1ps
// Front end: accepts chunks, keeps the table count and failure flag, and
// classifies each chunk into a queue command. Depends on dds_pkg.
module dds_front import dds_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [AddrInW-1:0]  chunk_address_i,
  input  logic [LenW-1:0]     chunk_length_i,
  input  logic                first_chunk_i,
  input  logic                last_chunk_i,
  input  logic                full_i,
  output logic                push_o,
  output chunk_cmd_t          cmd_o
);

  logic [CountW-1:0] count_q, count_d;
  logic              failed_q, failed_d;

  logic              accept;
  logic [CountW-1:0] eff_count;
  logic              eff_failed;
  logic [LenW:0]     low_sum;
  logic [NumW-1:0]   num_desc;
  logic [SegW-1:0]   addr_room;
  logic [CountW-1:0] table_room;
  logic              addr_fail;
  logic              full_fail;
  logic              active;
  err_e              err;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  assign eff_count  = first_chunk_i ? '0 : count_q;
  assign eff_failed = first_chunk_i ? 1'b0 : failed_q;
  assign active     = !eff_failed && (chunk_length_i != '0);

  // Descriptors needed: offset within the first 64 KiB page plus the length,
  // rounded up to whole pages.
  assign low_sum  = {11'b0, chunk_address_i[15:0]} + {1'b0, chunk_length_i} - 27'd1;
  assign num_desc = NumW'(low_sum[LenW:16]) + NumW'(1);

  // Index of the first descriptor whose start lies above 4 GiB.
  assign addr_room  = (chunk_address_i[AddrInW-1:32] != '0) ? '0
                    : Boundary - {1'b0, chunk_address_i[31:16]};
  assign table_room = CountW'(TABLE_ENTRIES) - eff_count;

  assign addr_fail = addr_room < {6'b0, num_desc};
  assign full_fail = {{(NumW-CountW){1'b0}}, table_room} < num_desc;

  always_comb begin
    priority if (addr_fail && ({4'b0, addr_room} <= {14'b0, table_room})) begin
      err = ERR_ADDR;
    end else if (full_fail) begin
      err = ERR_FULL;
    end else begin
      err = ERR_NONE;
    end
  end

  assign push_o        = accept && active;
  assign cmd_o.addr    = chunk_address_i[EntAddrW-1:0];
  assign cmd_o.len     = chunk_length_i;
  assign cmd_o.idx     = eff_count[IdxW-1:0];
  assign cmd_o.last    = last_chunk_i;
  assign cmd_o.err     = err;

  always_comb begin
    count_d  = count_q;
    failed_d = failed_q;
    if (accept) begin
      count_d  = eff_count;
      failed_d = eff_failed;
      if (active) begin
        if (err != ERR_NONE) begin
          failed_d = 1'b1;
        end else begin
          count_d = eff_count + num_desc[CountW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      failed_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      failed_q <= failed_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(TABLE_ENTRIES))
    else $error("table count beyond limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (err == ERR_NONE) |=> count_q == $past(eff_count) + $past(num_desc[CountW-1:0]))
    else $error("table count not advanced by descriptor count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (err != ERR_NONE) |=> failed_q)
    else $error("failed chunk did not mark the table");

endmodule

// File: rtl/dds_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front and back ends.
// Depends on dds_pkg for the command type.
module dds_fifo import dds_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  chunk_cmd_t data_i,
  output logic       full_o,
  input  logic       pop_i,
  output chunk_cmd_t data_o,
  output logic       empty_o
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = 2;

  chunk_cmd_t        mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(Depth))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q[PtrW-1:0] == wr_ptr_q - rd_ptr_q)
    else $error("queue pointers disagree with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

endmodule

// File: rtl/dds_back.sv
`timescale 1ns / 1ps
// Back end: takes classified chunks from the queue and emits one descriptor
// per cycle, when not stalled, into an output register. Depends on dds_pkg.
module dds_back import dds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                empty_i,
  input  chunk_cmd_t          cmd_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [EntAddrW-1:0] entry_address_o,
  output logic [EntLenW-1:0]  entry_length_o,
  output logic                end_of_table_o,
  output logic [IdxW-1:0]     entry_index_o,
  output logic [1:0]          error_code_o,
  output logic                run_last_o
);

  back_state_e         state_q, state_d;
  logic [EntAddrW-1:0] addr_q, addr_d;
  logic [LenW-1:0]     len_q, len_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic                last_q, last_d;
  err_e                err_q, err_d;

  logic                ovalid_q, ovalid_d;
  logic [EntAddrW-1:0] oaddr_q, oaddr_d;
  logic [EntLenW-1:0]  olen_q, olen_d;
  logic                oeot_q, oeot_d;
  logic [IdxW-1:0]     oidx_q, oidx_d;
  err_e                oerr_q, oerr_d;
  logic                olast_q, olast_d;

  logic                slot_free;
  logic [SegW-1:0]     rem;
  logic                seg_last;
  logic [SegW-1:0]     seg_len;

  assign slot_free = !ovalid_q || !out_stall_i;

  // Bytes up to the next 64 KiB boundary, clipped to what is left.
  assign rem      = Boundary - {1'b0, addr_q[15:0]};
  assign seg_last = {{(LenW-SegW){1'b0}}, rem} >= len_q;
  assign seg_len  = seg_last ? len_q[SegW-1:0] : rem;

  always_comb begin
    state_d  = state_q;
    addr_d   = addr_q;
    len_d    = len_q;
    idx_d    = idx_q;
    last_d   = last_q;
    err_d    = err_q;
    pop_o    = 1'b0;
    ovalid_d = ovalid_q && out_stall_i;
    oaddr_d  = oaddr_q;
    olen_d   = olen_q;
    oeot_d   = oeot_q;
    oidx_d   = oidx_q;
    oerr_d   = oerr_q;
    olast_d  = olast_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          addr_d  = cmd_i.addr;
          len_d   = cmd_i.len;
          idx_d   = cmd_i.idx;
          last_d  = cmd_i.last;
          err_d   = cmd_i.err;
          state_d = BK_RUN;
        end
      end
      BK_RUN: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          if (err_q != ERR_NONE) begin
            // A failed chunk yields a single zeroed result carrying the code.
            oaddr_d = '0;
            olen_d  = '0;
            oeot_d  = 1'b0;
            oidx_d  = '0;
            oerr_d  = err_q;
            olast_d = 1'b1;
            state_d = BK_IDLE;
          end else begin
            oaddr_d = addr_q;
            olen_d  = seg_len[EntLenW-1:0];
            oeot_d  = seg_last && last_q;
            oidx_d  = idx_q;
            oerr_d  = ERR_NONE;
            olast_d = seg_last;
            addr_d  = addr_q + {{(EntAddrW-SegW){1'b0}}, seg_len};
            len_d   = len_q - {{(LenW-SegW){1'b0}}, seg_len};
            idx_d   = idx_q + 1'b1;
            if (seg_last) begin
              state_d = BK_IDLE;
            end
          end
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    len_q   <= len_d;
    idx_q   <= idx_d;
    last_q  <= last_d;
    err_q   <= err_d;
    oaddr_q <= oaddr_d;
    olen_q  <= olen_d;
    oeot_q  <= oeot_d;
    oidx_q  <= oidx_d;
    oerr_q  <= oerr_d;
    olast_q <= olast_d;
  end

  assign out_valid_o     = ovalid_q;
  assign entry_address_o = oaddr_q;
  assign entry_length_o  = olen_q;
  assign end_of_table_o  = oeot_q;
  assign entry_index_o   = oidx_q;
  assign error_code_o    = oerr_q;
  assign run_last_o      = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (error_code_o != ERR_NONE) |-> run_last_o && (entry_length_o == '0))
    else $error("error result malformed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_table_o |-> run_last_o && (error_code_o == ERR_NONE))
    else $error("end of table away from the chunk's final descriptor");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_RUN) && (err_q == ERR_NONE) |-> len_q != '0)
    else $error("running with nothing left to split");

endmodule

// File: verif/dds_checker.sv
`timescale 1ns / 1ps
// Descriptor checker for the 64 KiB splitter: watches both channels, works out
// the descriptors each accepted chunk must produce, and compares them in order.
// Depends on dds_pkg for field widths and the error codes.
module dds_checker import dds_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic [AddrInW-1:0]  chunk_address_i,
  input  logic [LenW-1:0]     chunk_length_i,
  input  logic                first_chunk_i,
  input  logic                last_chunk_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic [EntAddrW-1:0] entry_address_i,
  input  logic [EntLenW-1:0]  entry_length_i,
  input  logic                end_of_table_i,
  input  logic [IdxW-1:0]     entry_index_i,
  input  logic [1:0]          error_code_i,
  input  logic                run_last_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  localparam longint unsigned SegBytes = 64'h1_0000;
  localparam longint unsigned SegMask  = 64'h0_ffff;
  localparam longint unsigned AddrTop  = 64'hffff_ffff;
  localparam int unsigned     PrintCap = 40;

  typedef struct packed {
    logic [EntAddrW-1:0] addr;
    logic [EntLenW-1:0]  len;
    logic                eot;
    logic [IdxW-1:0]     idx;
    err_e                err;
    logic                run_last;
  } descriptor_t;

  descriptor_t        descs_due[$];
  logic [CountW-1:0]  table_count;
  logic               table_failed;
  int unsigned        seen;

  task automatic report_mismatch(input string what);
    if (mismatches_o < PrintCap) begin
      $display("%0t ns: descriptor %0d: %s", $time, seen, what);
    end
    mismatches_o++;
  endtask

  // Cuts one chunk at 64 KiB boundaries. A chunk that runs past 4 GiB or past
  // the table end yields a single error item and poisons the table.
  function automatic void split_chunk(input logic [AddrInW-1:0] start,
                                      input logic [LenW-1:0] bytes,
                                      input logic first, input logic last);
    descriptor_t     pieces[$];
    descriptor_t     d;
    longint unsigned addr;
    longint unsigned left;
    longint unsigned span;
    int unsigned     count;
    err_e            err;
    addr = start;
    left = bytes;
    err  = ERR_NONE;
    if (first) begin
      table_count  = '0;
      table_failed = 1'b0;
    end
    if (table_failed || left == 0) return;
    count = table_count;
    while (left > 0) begin
      if (addr > AddrTop) begin
        err = ERR_ADDR;
        break;
      end
      if (count >= TABLE_ENTRIES) begin
        err = ERR_FULL;
        break;
      end
      span = SegBytes - (addr & SegMask);
      if (span > left) span = left;
      d.addr     = EntAddrW'(addr);
      d.len      = EntLenW'(span);
      d.eot      = 1'b0;
      d.idx      = IdxW'(count);
      d.err      = ERR_NONE;
      d.run_last = 1'b0;
      pieces.push_back(d);
      count++;
      addr += span;
      left -= span;
    end
    if (err != ERR_NONE) begin
      table_failed = 1'b1;
      d          = '0;
      d.err      = err;
      d.run_last = 1'b1;
      descs_due.push_back(d);
    end else begin
      table_count = CountW'(count);
      pieces[pieces.size()-1].eot      = last;
      pieces[pieces.size()-1].run_last = 1'b1;
      foreach (pieces[i]) descs_due.push_back(pieces[i]);
    end
  endfunction

  task automatic check_descriptor();
    descriptor_t want;
    if (descs_due.size() == 0) begin
      report_mismatch("descriptor arrived with none expected");
      return;
    end
    want = descs_due.pop_front();
    if (entry_address_i !== want.addr)
      report_mismatch($sformatf("entry_address %h, expected %h", entry_address_i, want.addr));
    if (entry_length_i !== want.len)
      report_mismatch($sformatf("entry_length %h, expected %h", entry_length_i, want.len));
    if (end_of_table_i !== want.eot)
      report_mismatch($sformatf("end_of_table %b, expected %b", end_of_table_i, want.eot));
    if (entry_index_i !== want.idx)
      report_mismatch($sformatf("entry_index %0d, expected %0d", entry_index_i, want.idx));
    if (error_code_i !== want.err)
      report_mismatch($sformatf("error_code %0d, expected %0d", error_code_i, want.err));
    if (run_last_i !== want.run_last)
      report_mismatch($sformatf("run_last %b, expected %b", run_last_i, want.run_last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_count  = '0;
      table_failed = 1'b0;
      descs_due.delete();
      seen         = 0;
      pending_o   <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        split_chunk(chunk_address_i, chunk_length_i, first_chunk_i, last_chunk_i);
      end
      if (out_valid_i && !out_stall_i) begin
        check_descriptor();
        seen++;
      end
      pending_o <= descs_due.size();
    end
  end

endmodule

// File: verif/tb_dma_descriptor_splitter_64k_core.sv
`timescale 1ns / 1ps
// Testbench top for the 64 KiB descriptor splitter: clock, reset, chunk
// stimulus and receiver stalls; dds_checker does the predicting and comparing.
// Depends on dds_pkg, dma_descriptor_splitter_64k_core and dds_checker.
module tb_dma_descriptor_splitter_64k_core;
  import dds_pkg::*;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned ItemTarget   = 270;
  localparam int unsigned CalmFrom     = 230;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned DrainCycles  = 16;
  localparam int unsigned CycleLimit   = 2_000_000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [AddrInW-1:0]  chunk_address_i = '0;
  logic [LenW-1:0]     chunk_length_i = '0;
  logic                first_chunk_i = 1'b0;
  logic                last_chunk_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [EntAddrW-1:0] entry_address_o;
  logic [EntLenW-1:0]  entry_length_o;
  logic                end_of_table_o;
  logic [IdxW-1:0]     entry_index_o;
  logic [1:0]          error_code_o;
  logic                run_last_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned sent = 0;
  int unsigned cycle_count = 0;
  bit          calm = 1'b0;
  bit          pressing = 1'b0;
  bit          hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  dma_descriptor_splitter_64k_core #(
    .TABLE_ENTRIES(TableEntries)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .chunk_address_i(chunk_address_i),
    .chunk_length_i (chunk_length_i),
    .first_chunk_i  (first_chunk_i),
    .last_chunk_i   (last_chunk_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .entry_address_o(entry_address_o),
    .entry_length_o (entry_length_o),
    .end_of_table_o (end_of_table_o),
    .entry_index_o  (entry_index_o),
    .error_code_o   (error_code_o),
    .run_last_o     (run_last_o)
  );

  dds_checker #(
    .TABLE_ENTRIES(TableEntries)
  ) checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .chunk_address_i(chunk_address_i),
    .chunk_length_i (chunk_length_i),
    .first_chunk_i  (first_chunk_i),
    .last_chunk_i   (last_chunk_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .entry_address_i(entry_address_o),
    .entry_length_i (entry_length_o),
    .end_of_table_i (end_of_table_o),
    .entry_index_i  (entry_index_o),
    .error_code_i   (error_code_o),
    .run_last_i     (run_last_o),
    .mismatches_o   (mismatches),
    .pending_o      (pending)
  );

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("[dma_descriptor_splitter_64k_core] ERROR");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high, so a following item can go out back to back.
  task automatic offer_chunk(input logic [AddrInW-1:0] addr, input logic [LenW-1:0] bytes,
                             input logic first, input logic last);
    if (!calm && !pressing && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(18, 1)) @(negedge clk_i);
    end
    chunk_address_i <= addr;
    chunk_length_i  <= bytes;
    first_chunk_i   <= first;
    last_chunk_i    <= last;
    in_valid_i      <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  function automatic logic [LenW-1:0] pick_length();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return LenW'($urandom_range(4096, 1));
    if (r < 80) return LenW'($urandom_range(196608, 1));
    if (r < 95) return LenW'($urandom_range(1048576, 1));
    return LenW'($urandom_range(33554432, 1));
  endfunction

  // Addresses cluster near 64 KiB boundaries and near the 4 GiB top; wild
  // ones also set the upper byte.
  function automatic logic [AddrInW-1:0] pick_address(input bit wild);
    logic [31:0] low;
    int unsigned r;
    r   = $urandom_range(99);
    low = $urandom();
    if (r < 20) low[15:0] = 16'hffff - 16'($urandom_range(255));
    else if (r < 25) low = 32'hffff_ffff - 32'($urandom_range(200000));
    if (wild) return {8'($urandom()), low};
    return {8'h00, low};
  endfunction

  // Receiver: stall bursts at a density redrawn for each phase, one long hold on
  // request, and no stalls once the run has gone calm.
  initial begin
    int unsigned stall_pct;
    int unsigned phase_left;
    bit          hold_done;
    stall_pct  = 0;
    phase_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase_left == 0) begin
        case ($urandom_range(2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
        phase_left = 64;
      end
      phase_left--;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(18, 1)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned n;
    bit          broken;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Boundary splits, the 65536 encoding and appending after a last chunk.
    offer_chunk(40'h00_0000_0000, 26'd1, 1'b1, 1'b0);
    offer_chunk(40'h00_0000_ffff, 26'd2, 1'b0, 1'b0);
    offer_chunk(40'h00_0001_0000, 26'h001_0000, 1'b0, 1'b0);
    offer_chunk(40'h00_0001_2345, 26'h003_0000, 1'b0, 1'b1);
    offer_chunk(40'h00_ffff_ffff, 26'd1, 1'b0, 1'b0);
    // A chunk running past 4 GiB fails; the failed table then swallows items.
    offer_chunk(40'h00_ffff_ffff, 26'd2, 1'b0, 1'b0);
    offer_chunk(40'h00_0000_1000, 26'd100, 1'b0, 1'b1);
    // Zero-length chunks: one with first set still clears the failure.
    offer_chunk(40'h00_0000_0000, 26'd0, 1'b1, 1'b0);
    offer_chunk(40'h00_0000_1000, 26'd10, 1'b0, 1'b0);
    offer_chunk(40'h00_0000_2000, 26'd0, 1'b0, 1'b1);
    offer_chunk(40'hff_ffff_ffff, 26'h200_0000, 1'b1, 1'b1);
    // A full table of 64 descriptors, then one more chunk overflows it.
    offer_chunk(40'h00_0000_0000, 26'h040_0000, 1'b1, 1'b1);
    offer_chunk(40'h00_0000_0000, 26'd1, 1'b0, 1'b0);
    offer_chunk(40'h00_0000_8000, 26'h040_0000, 1'b1, 1'b1);
    // Filling up to the last index, then overflowing by one.
    offer_chunk(40'h00_0000_0000, 26'h03f_0000, 1'b1, 1'b0);
    offer_chunk(40'h00_003f_0000, 26'd1, 1'b0, 1'b0);
    offer_chunk(40'h00_0000_0000, 26'd1, 1'b0, 1'b1);
    // Alternating bit patterns on every field.
    offer_chunk(40'haa_aaaa_aaaa, 26'h155_5555, 1'b1, 1'b0);
    offer_chunk(40'h55_5555_5555, 26'h0aa_aaaa, 1'b1, 1'b1);
    offer_chunk(40'h00_5555_5555, 26'h001_5555, 1'b1, 1'b1);
    offer_chunk(40'h00_aaaa_aaaa, 26'h000_aaaa, 1'b1, 1'b1);
    offer_chunk(40'h00_0000_0000, 26'h200_0000, 1'b1, 1'b1);

    // Back-to-back chunks against a long output hold, so the queue fills.
    pressing = 1'b1;
    hold_req = 1'b1;
    for (int k = 0; k < 16; k++) begin
      offer_chunk(pick_address(1'b0), LenW'($urandom_range(196608, 65537)),
                  k == 0, k == 15);
    end
    pressing = 1'b0;

    // Mostly well-formed tables with random content, some broken ones.
    while (sent < ItemTarget) begin
      n      = $urandom_range(6, 1);
      broken = $urandom_range(99) < 15;
      for (int k = 0; k < n && sent < ItemTarget; k++) begin
        if (sent >= CalmFrom) calm = 1'b1;
        if (broken) begin
          offer_chunk(pick_address(1'b1), pick_length(), 1'($urandom_range(1)),
                      1'($urandom_range(1)));
        end else begin
          offer_chunk(pick_address(1'b0), pick_length(), k == 0, k == n - 1);
        end
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[dma_descriptor_splitter_64k_core] OK");
    end else begin
      $display("[dma_descriptor_splitter_64k_core] ERROR");
    end
    $finish;
  end

endmodule
